// ----- rtl/weighted_track_mixer_macros.svh -----
// ---------------------------------------------------------------------------
// weighted_track_mixer assertion macros
// concurrent checks, empty when synthesised
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_TRACK_MIXER_MACROS_SVH
`define WEIGHTED_TRACK_MIXER_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define WTM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted_track_mixer: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define WTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted_track_mixer: next-cycle check failed");

`else

`define WTM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define WTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/wtm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtm_pkg
// widths, register indexes and pipeline types of the track mixer
// ---------------------------------------------------------------------------
package wtm_pkg;

    localparam int NUM_TRACKS   = 4;
    localparam int FIELD_TRACKS = 4;
    localparam int LANES        = (NUM_TRACKS < FIELD_TRACKS) ? NUM_TRACKS : FIELD_TRACKS;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 16;
    localparam int FRAC_W   = 12;
    localparam int TC_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W = SAMPLE_W + VOL_W + 1;
    localparam int SUM_W  = PROD_W + $clog2(NUM_TRACKS) + 1;
    localparam int MAG_W  = SUM_W - FRAC_W;

    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QW         = DIV_STAGES * DIV_STEPS;

    // lanes, merge, divider stages, output register
    localparam int NSTG = DIV_STAGES + 3;

    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME0     = CFG_IDX_W'(1);

    localparam logic [TC_W-1:0]  TRACK_COUNT_RST = TC_W'(1);
    localparam logic [VOL_W-1:0] VOLUME_RST      = VOL_W'(4096);

    localparam logic [QW-1:0] POS_LIMIT = QW'(32767);
    localparam logic [QW-1:0] NEG_LIMIT = QW'(32768);

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic                     last;
        logic signed [SUM_W-1:0]  sum;
    } mrg_t;

    typedef struct packed {
        logic            neg;
        logic            last;
        logic [TC_W-1:0] rem;
        logic [QW-1:0]   num;
    } div_t;

endpackage
`default_nettype wire

// ----- rtl/wtm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtm channel interfaces
// slot input, mixed output and register write channels
// ---------------------------------------------------------------------------
interface wtm_in_if;
    import wtm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_track0;
    logic signed [SAMPLE_W-1:0] sample_track1;
    logic signed [SAMPLE_W-1:0] sample_track2;
    logic signed [SAMPLE_W-1:0] sample_track3;
    logic                       present_track0;
    logic                       present_track1;
    logic                       present_track2;
    logic                       present_track3;
    logic                       last_in;

    modport source (
        output valid, sample_track0, sample_track1, sample_track2, sample_track3,
        output present_track0, present_track1, present_track2, present_track3, last_in,
        input  ready
    );
    modport sink (
        input  valid, sample_track0, sample_track1, sample_track2, sample_track3,
        input  present_track0, present_track1, present_track2, present_track3, last_in,
        output ready
    );
endinterface

interface wtm_out_if;
    import wtm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       clipped;
    logic                       last_out;

    modport source (output valid, mixed_sample, clipped, last_out, input ready);
    modport sink (input valid, mixed_sample, clipped, last_out, output ready);
endinterface

interface wtm_cfg_if;
    import wtm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/wtm_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtm_lane
// one track lane: gated sample times volume, registered product
// ---------------------------------------------------------------------------
module wtm_lane (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [wtm_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [wtm_pkg::VOL_W-1:0]          volume,
    input  wire logic                               take,
    output wtm_pkg::prod_t                          product
);
    import wtm_pkg::*;

    prod_t product_reg;
    prod_t product_next;

    always_comb
    begin
        if (take)
        begin
            // both operands widened to the product width before the multiply
            product_next = prod_t'(sample) * prod_t'($signed({1'b0, volume}));
        end
        else
        begin
            product_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule
`default_nettype wire

// ----- rtl/wtm_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtm_merge
// adds the lane products into one exact sum
// ---------------------------------------------------------------------------
module wtm_merge (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire wtm_pkg::prod_t products [wtm_pkg::LANES],
    input  wire logic           last_in,
    output wtm_pkg::mrg_t       merged
);
    import wtm_pkg::*;

    mrg_t merged_reg;
    mrg_t merged_next;

    always_comb
    begin
        merged_next.last = last_in;
        merged_next.sum  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            merged_next.sum = merged_next.sum + SUM_W'(products[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            merged_reg <= merged_next;
        end
    end

    assign merged = merged_reg;

endmodule
`default_nettype wire

// ----- rtl/wtm_div_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtm_div_stage
// restoring division by the track count, eight quotient bits per stage
// ---------------------------------------------------------------------------
module wtm_div_stage (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [wtm_pkg::TC_W-1:0]  divisor,
    input  wire wtm_pkg::div_t             d_in,
    output wtm_pkg::div_t                  d_out
);
    import wtm_pkg::*;

    div_t d_reg;
    div_t d_next;

    always_comb
    begin
        logic [TC_W:0] trial;
        d_next = d_in;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial       = {d_next.rem, d_next.num[QW-1]};
            d_next.num  = {d_next.num[QW-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                d_next.rem    = TC_W'(trial - {1'b0, divisor});
                d_next.num[0] = 1'b1;
            end
            else
            begin
                d_next.rem = trial[TC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
`default_nettype wire

// ----- rtl/weighted_track_mixer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// datapath: an input transfer reaches the mixed sample at the output through
// six registers (lane multiply, merge add, three divider stages, saturation)
// throughput: one slot per cycle while mix.ready takes results; every stage holds its
// own valid bit, so bubbles close up and a waiting result stalls only the stages behind it
// reset: pipeline valid bits clear, track count returns to 1, volumes to unity
// ---------------------------------------------------------------------------
// weighted_track_mixer
// per-track volume, sum, divide by track count and saturate to 16 bits
// ---------------------------------------------------------------------------
`include "weighted_track_mixer_macros.svh"

module weighted_track_mixer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wtm_cfg_if.sink    cfg,
    wtm_in_if.sink     samples,
    wtm_out_if.source  mix
);
    import wtm_pkg::*;

    logic [TC_W-1:0]  track_count_reg;
    logic [VOL_W-1:0] volume_reg [FIELD_TRACKS];

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] valid_in;
    logic [NSTG-1:0] adv;

    logic signed [SAMPLE_W-1:0] sample_arr  [FIELD_TRACKS];
    logic                       present_arr [FIELD_TRACKS];
    prod_t                      products    [LANES];
    logic                       last0_reg;

    mrg_t            merged;
    logic            sum_neg;
    logic [SUM_W-1:0] sum_mag;
    logic [TC_W-1:0] divisor;
    div_t            div_q [DIV_STAGES+1];

    logic signed [SAMPLE_W-1:0] mixed_reg;
    logic signed [SAMPLE_W-1:0] mixed_next;
    logic                       clip_reg;
    logic                       clip_next;
    logic                       last_reg;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_count_reg <= TRACK_COUNT_RST;
            for (int i = 0; i < FIELD_TRACKS; i++)
            begin
                volume_reg[i] <= VOLUME_RST;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_TRACK_COUNT)
            begin
                track_count_reg <= cfg.data[TC_W-1:0];
            end
            for (int i = 0; i < FIELD_TRACKS; i++)
            begin
                if (cfg.index == REG_VOLUME0 + CFG_IDX_W'(i))
                begin
                    volume_reg[i] <= cfg.data[VOL_W-1:0];
                end
            end
        end
    end

    // stage handshake: a stage loads when empty or when the one after it moves
    always_comb
    begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || mix.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign valid_in   = {valid_reg[NSTG-2:0], samples.valid};
    assign valid_next = (adv & valid_in) | (~adv & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign samples.ready = adv[0];

    // lanes
    assign sample_arr[0]  = samples.sample_track0;
    assign sample_arr[1]  = samples.sample_track1;
    assign sample_arr[2]  = samples.sample_track2;
    assign sample_arr[3]  = samples.sample_track3;
    assign present_arr[0] = samples.present_track0;
    assign present_arr[1] = samples.present_track1;
    assign present_arr[2] = samples.present_track2;
    assign present_arr[3] = samples.present_track3;

    for (genvar t = 0; t < LANES; t++)
    begin : g_lane
        wtm_lane u_lane (
            .clk     (clk),
            .en      (adv[0]),
            .sample  (sample_arr[t]),
            .volume  (volume_reg[t]),
            .take    (present_arr[t] && (TC_W'(t) < track_count_reg)),
            .product (products[t])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            last0_reg <= samples.last_in;
        end
    end

    wtm_merge u_merge (
        .clk      (clk),
        .en       (adv[1]),
        .products (products),
        .last_in  (last0_reg),
        .merged   (merged)
    );

    // magnitude, with the fraction bits dropped before the integer divide
    assign sum_neg = merged.sum[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-merged.sum) : SUM_W'(merged.sum);
    assign divisor = (track_count_reg == '0) ? TC_W'(1) : track_count_reg;

    assign div_q[0].neg  = sum_neg;
    assign div_q[0].last = merged.last;
    assign div_q[0].rem  = '0;
    assign div_q[0].num  = QW'(sum_mag[SUM_W-1:FRAC_W]);

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        wtm_div_stage u_div (
            .clk     (clk),
            .en      (adv[2+g]),
            .divisor (divisor),
            .d_in    (div_q[g]),
            .d_out   (div_q[g+1])
        );
    end

    // saturation
    always_comb
    begin
        clip_next  = 1'b0;
        mixed_next = SAMPLE_W'(div_q[DIV_STAGES].num);
        if (div_q[DIV_STAGES].neg)
        begin
            if (div_q[DIV_STAGES].num > NEG_LIMIT)
            begin
                clip_next  = 1'b1;
                mixed_next = SAMPLE_W'(NEG_LIMIT);
            end
            else
            begin
                mixed_next = SAMPLE_W'(-div_q[DIV_STAGES].num);
            end
        end
        else if (div_q[DIV_STAGES].num > POS_LIMIT)
        begin
            clip_next  = 1'b1;
            mixed_next = SAMPLE_W'(POS_LIMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NSTG-1])
        begin
            mixed_reg <= mixed_next;
            clip_reg  <= clip_next;
            last_reg  <= div_q[DIV_STAGES].last;
        end
    end

    assign mix.valid        = valid_reg[NSTG-1];
    assign mix.mixed_sample = mixed_reg;
    assign mix.clipped      = clip_reg;
    assign mix.last_out     = last_reg;

    `WTM_ASSERT_IMPLIES(a_clip_at_limit, clk, rst_n, mix.valid && mix.clipped, (mix.mixed_sample == 16'sh7FFF) || (mix.mixed_sample == -16'sh8000))
    `WTM_ASSERT_IMPLIES(a_ready_with_room, clk, rst_n, valid_reg != {NSTG{1'b1}}, samples.ready)
    `WTM_ASSERT_NEXT(a_merge_moves, clk, rst_n, valid_reg[0] && adv[1], valid_reg[1])
    `WTM_ASSERT_IMPLIES(a_no_tracks_silent, clk, rst_n, mix.valid && (track_count_reg == '0), (mix.mixed_sample == '0) && !mix.clipped)

endmodule
`default_nettype wire
